>>> rtl/core/bged_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector package
// Shared codes, reset values, arithmetic constants and types of the detector.
// ----------------------------------------------------------------------------
package bged_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd4;

    localparam logic        COLOR_MODE_RST     = 1'b1;
    localparam logic [11:0] FRAME_WIDTH_RST    = 12'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic [7:0]  BIN_THRESHOLD_RST  = 8'd127;
    localparam logic [8:0]  EDGE_THRESHOLD_RST = 9'd15;

    localparam int LUMA_W = 24;
    localparam logic [LUMA_W-1:0] LUMA_WR = 24'd13933;
    localparam logic [LUMA_W-1:0] LUMA_WG = 24'd46871;
    localparam logic [LUMA_W-1:0] LUMA_WB = 24'd4732;

    localparam logic [7:0] GRAD_FULL = 8'd255;
    localparam logic [7:0] GRAD_HALF = 8'd127;
    localparam logic [7:0] GRAD_NONE = 8'd0;
    localparam logic [7:0] EDGE_ON   = 8'd255;
    localparam logic [7:0] EDGE_OFF  = 8'd0;

    localparam int MAG_SQ_W = 19;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req_type;

    typedef struct packed {
        logic older;
        logic newer;
    } t_lb_entry;

    typedef struct packed {
        logic older_a;
        logic newer_a;
        logic newer_b;
    } t_lb_rd;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last_of_frame;
    } t_result;

endpackage

>>> rtl/core/bged_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector channels
// Pixel request, edge result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bged_pix_if
    import bged_pkg::*;
();
    logic       valid;
    logic       ready;
    t_req_type  req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output req_type, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input req_type, input red, input green,
                    input blue, output ready);
endinterface

interface bged_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_value;
    logic       last_of_frame;

    modport source (output valid, output edge_value, output last_of_frame,
                    input ready);
    modport sink   (input valid, input edge_value, input last_of_frame,
                    output ready);
endinterface

interface bged_cfg_if
    import bged_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/bged_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector line memory
// Two rows of binary pixels, one write and two reads per cycle, with the
// write of the previous cycle forwarded onto reads of the same column.
// ----------------------------------------------------------------------------
module bged_line_buf
    import bged_pkg::*;
#(
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_lb_entry     i_wr_data,
    output t_lb_rd        o_rd
);

    t_lb_entry     r_mem [DEPTH];
    t_lb_entry     r_rd_a;
    t_lb_entry     r_rd_b;
    t_lb_entry     r_lw_data;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [AW-1:0] r_lw_addr;
    logic          r_lw_en;
    logic          w_hit_a;
    logic          w_hit_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a    <= r_mem[i_rd_addr_a];
        r_rd_b    <= r_mem[i_rd_addr_b];
        r_addr_a  <= i_rd_addr_a;
        r_addr_b  <= i_rd_addr_b;
        r_lw_addr <= i_wr_addr;
        r_lw_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_en <= 1'b0;
        end else begin
            r_lw_en <= i_wr_en;
        end
    end

    assign w_hit_a = r_lw_en && (r_lw_addr == r_addr_a);
    assign w_hit_b = r_lw_en && (r_lw_addr == r_addr_b);

    always_comb begin
        o_rd.older_a = w_hit_a ? r_lw_data.older : r_rd_a.older;
        o_rd.newer_a = w_hit_a ? r_lw_data.newer : r_rd_a.newer;
        o_rd.newer_b = w_hit_b ? r_lw_data.newer : r_rd_b.newer;
    end

endmodule

>>> rtl/core/bged_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector result queue
// Small register queue that decouples the pipeline from the result sink.
// ----------------------------------------------------------------------------
module bged_out_queue
    import bged_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_push_data,
    output logic [QUEUE_CW-1:0] o_count,
    bged_res_if.source          o_res
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                w_pop;

    assign o_res.valid         = (r_count != '0);
    assign o_res.edge_value    = r_mem[r_rd_ptr].edge_value;
    assign o_res.last_of_frame = r_mem[r_rd_ptr].last_of_frame;
    assign w_pop               = o_res.valid && o_res.ready;
    assign o_count             = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/core/binary_gradient_edge_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector
// Accepts one request per clock while the result queue has room: pixels in
// raster order and drain requests that flush the last row after a frame. A
// pixel is converted to luma, binarized against bin_threshold and stored in
// a two-row line memory of MAX_WIDTH entries with one write and two read
// ports; each pixel request reads its column, modifies it and writes it
// back, and the previous cycle's write is forwarded to the reads. The edge
// result of row y-1 is formed when the same column of row y arrives and is
// registered in the r1 and r2 stages. Results pass through a four-entry
// queue that also reserves an entry for every request in flight, so a
// stalled sink only stops input once the queued results and the requests
// in flight fill its four entries. No clearing pass is run after reset.
// Register writes take effect for the next request.
// ----------------------------------------------------------------------------
module binary_gradient_edge_detector
    import bged_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bged_cfg_if.sink   i_cfg,
    bged_pix_if.sink   i_pix,
    bged_res_if.source o_edge
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic        r_color_mode;
    logic [11:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [7:0]  r_bin_thr;
    logic [8:0]  r_edge_thr;
    logic [9:0]  w_lim;
    logic [MAG_SQ_W-1:0] r_lim_sq;

    logic [AW-1:0] w_wm1;
    logic [RW-1:0] w_hm1;

    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_drain_col, n_drain_col;
    logic          r_draining, n_draining;

    logic          w_accept;
    logic          w_is_pix;
    logic [AW-1:0] w_col_use;
    logic [RW-1:0] w_row_use;
    logic [AW-1:0] w_x;
    logic [RW-1:0] w_y;
    logic          w_lastc;
    logic [AW-1:0] w_rd_addr_b;

    logic              r1_valid;
    logic              r1_pix;
    logic              r1_prod;
    logic              r1_first;
    logic              r1_lastc;
    logic              r1_y1;
    logic              r1_lof;
    logic [AW-1:0]     r1_x;
    logic [7:0]        r1_red;
    logic [LUMA_W-1:0] r1_prod_r;
    logic [LUMA_W-1:0] r1_prod_g;
    logic [LUMA_W-1:0] r1_prod_b;

    logic              r_left_pix;
    logic              r_left_drn;
    t_lb_rd            w_lb_rd;
    t_lb_entry         w_wr_data;
    logic              w_wr_en;
    logic [LUMA_W-1:0] w_luma_sum;
    logic [7:0]        w_luma;
    logic              w_cur;
    logic              w_left;
    logic [7:0]        w_gx;
    logic [7:0]        w_gy;

    logic          r2_valid;
    logic          r2_lof;
    logic [7:0]    r2_gx;
    logic [7:0]    r2_gy;
    logic [MAG_SQ_W-1:0] w_mag_sq;
    t_result       w_push_data;

    logic [QUEUE_CW-1:0] w_q_count;
    logic [QUEUE_CW-1:0] w_load;

    // Register port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode   <= COLOR_MODE_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_bin_thr      <= BIN_THRESHOLD_RST;
            r_edge_thr     <= EDGE_THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COLOR_MODE:     r_color_mode   <= i_cfg.data[0];
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg.data[11:0];
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg.data[12:0];
                CFG_BIN_THRESHOLD:  r_bin_thr      <= i_cfg.data[7:0];
                CFG_EDGE_THRESHOLD: r_edge_thr     <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign w_lim = 10'(r_edge_thr) + 10'd1;

    always_ff @(posedge i_clk) begin
        r_lim_sq <= MAG_SQ_W'(w_lim) * MAG_SQ_W'(w_lim);
    end

    always_comb begin
        if (r_frame_width < 12'd2) begin
            w_wm1 = AW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_wm1 = AW'(MAX_WIDTH - 1);
        end else begin
            w_wm1 = AW'(32'(r_frame_width) - 32'd1);
        end
        if (r_frame_height < 13'd2) begin
            w_hm1 = RW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            w_hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            w_hm1 = RW'(32'(r_frame_height) - 32'd1);
        end
    end

    // Request stage: position, counters and line memory read addresses.
    assign w_load      = w_q_count + QUEUE_CW'(r1_valid) + QUEUE_CW'(r2_valid);
    assign i_pix.ready = (w_load < QUEUE_CW'(QUEUE_DEPTH));
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_comb begin
        unique case (i_pix.req_type)
            REQ_PIXEL: w_is_pix = 1'b1;
            REQ_DRAIN: w_is_pix = 1'b0;
        endcase
        w_col_use = r_draining ? '0 : r_col;
        w_row_use = r_draining ? '0 : r_row;
        if (w_is_pix) begin
            w_x = (w_col_use > w_wm1) ? w_wm1 : w_col_use;
        end else begin
            w_x = (r_drain_col > w_wm1) ? w_wm1 : r_drain_col;
        end
        w_y         = (w_row_use > w_hm1) ? w_hm1 : w_row_use;
        w_lastc     = (w_x == w_wm1);
        w_rd_addr_b = (!w_is_pix && w_lastc) ? w_x - AW'(1) : w_x + AW'(1);

        n_col       = r_col;
        n_row       = r_row;
        n_drain_col = r_drain_col;
        n_draining  = r_draining;
        if (w_accept) begin
            if (w_is_pix) begin
                n_draining  = 1'b0;
                n_drain_col = '0;
                n_row       = w_row_use;
                if (w_lastc) begin
                    n_col = '0;
                    if (w_y == w_hm1) begin
                        n_row      = '0;
                        n_draining = 1'b1;
                    end else begin
                        n_row = w_y + RW'(1);
                    end
                end else begin
                    n_col = w_x + AW'(1);
                end
            end else if (r_draining) begin
                if (w_lastc) begin
                    n_draining  = 1'b0;
                    n_drain_col = '0;
                end else begin
                    n_drain_col = w_x + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_drain_col <= n_drain_col;
            r_draining  <= n_draining;
            r1_valid    <= w_accept && (w_is_pix || r_draining);
            r2_valid    <= r1_valid && r1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pix    <= w_is_pix;
        r1_prod   <= w_is_pix ? (w_y != '0) : 1'b1;
        r1_first  <= (w_x == '0);
        r1_lastc  <= w_lastc;
        r1_y1     <= (w_y == RW'(1));
        r1_lof    <= !w_is_pix && w_lastc;
        r1_x      <= w_x;
        r1_red    <= i_pix.red;
        r1_prod_r <= LUMA_WR * LUMA_W'(i_pix.red);
        r1_prod_g <= LUMA_WG * LUMA_W'(i_pix.green);
        r1_prod_b <= LUMA_WB * LUMA_W'(i_pix.blue);
    end

    bged_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (w_x),
        .i_rd_addr_b (w_rd_addr_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (r1_x),
        .i_wr_data   (w_wr_data),
        .o_rd        (w_lb_rd)
    );

    // Gradient stage: binarize, form the differences, write the column back.
    assign w_luma_sum = r1_prod_r + r1_prod_g + r1_prod_b;
    assign w_luma     = r_color_mode ? w_luma_sum[LUMA_W-1 -: 8] : r1_red;
    assign w_cur      = (w_luma > r_bin_thr);

    assign w_wr_en         = r1_valid && r1_pix;
    assign w_wr_data.older = w_lb_rd.newer_a;
    assign w_wr_data.newer = w_cur;

    always_comb begin
        if (r1_pix) begin
            w_left = r_left_pix;
        end else if (r1_lastc) begin
            w_left = w_lb_rd.newer_b;
        end else begin
            w_left = r_left_drn;
        end

        if (r1_first) begin
            w_gx = (w_lb_rd.newer_b != w_lb_rd.newer_a) ? GRAD_FULL : GRAD_NONE;
        end else if (r1_lastc) begin
            w_gx = (w_lb_rd.newer_a != w_left) ? GRAD_FULL : GRAD_NONE;
        end else begin
            w_gx = (w_lb_rd.newer_b != w_left) ? GRAD_HALF : GRAD_NONE;
        end

        if (!r1_pix) begin
            w_gy = (w_lb_rd.newer_a != w_lb_rd.older_a) ? GRAD_FULL : GRAD_NONE;
        end else if (r1_y1) begin
            w_gy = (w_cur != w_lb_rd.newer_a) ? GRAD_FULL : GRAD_NONE;
        end else begin
            w_gy = (w_cur != w_lb_rd.older_a) ? GRAD_HALF : GRAD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            if (r1_pix) begin
                r_left_pix <= w_lb_rd.newer_a;
            end else begin
                r_left_drn <= w_lb_rd.newer_a;
            end
        end
        r2_gx  <= w_gx;
        r2_gy  <= w_gy;
        r2_lof <= r1_lof;
    end

    // Magnitude stage.
    assign w_mag_sq = MAG_SQ_W'(r2_gx) * MAG_SQ_W'(r2_gx)
                    + MAG_SQ_W'(r2_gy) * MAG_SQ_W'(r2_gy);
    assign w_push_data.edge_value    = (w_mag_sq >= r_lim_sq) ? EDGE_ON : EDGE_OFF;
    assign w_push_data.last_of_frame = r2_lof;

    bged_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r2_valid),
        .i_push_data (w_push_data),
        .o_count     (w_q_count),
        .o_res       (o_edge)
    );

`ifndef SYNTHESIS
    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_q_count) + 32'(r1_valid) + 32'(r2_valid)) <= 32'(QUEUE_DEPTH))
        else $error("Requests in flight exceed the result queue space.");

    a_drain_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_col == '0))
        else $error("Column counter is not at zero while draining.");

    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_draining) |-> (r_row == '0 && r_drain_col == '0))
        else $error("Drain started without the frame counters at zero.");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary gradient edge detector testbench
// Streams frames of pixels and drain requests through the detector with
// random gaps and result stalls, predicts every edge result from a
// behavioral model of the line buffers and gradients, and compares each
// result field by field. Directed frames cover the size and threshold
// extremes and the corner cases of the frame sequencing. Random phases
// follow, with register changes between frames and size cuts mid-frame.
// ----------------------------------------------------------------------------
module testbench;
    import bged_pkg::*;

    localparam int MAX_COLS    = 2048;
    localparam int MAX_ROWS    = 4096;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        t_req_type  kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_req;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  pix_valid = 1'b0;
    t_pixel_req            pix_item  = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bged_cfg_if cfg_bus ();
    bged_pix_if pix_bus ();
    bged_res_if edge_bus ();

    assign pix_bus.valid    = pix_valid;
    assign pix_bus.req_type = pix_item.kind;
    assign pix_bus.red      = pix_item.red;
    assign pix_bus.green    = pix_item.green;
    assign pix_bus.blue     = pix_item.blue;
    assign edge_bus.ready   = res_ready;
    assign cfg_bus.valid    = cfg_valid;
    assign cfg_bus.index    = cfg_index;
    assign cfg_bus.data     = cfg_data;

    binary_gradient_edge_detector #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_edge  (edge_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pixel_req pixel_requests[$];
    t_reg_write reg_writes[$];
    t_result    edge_due[$];

    bit cfg_color  = COLOR_MODE_RST;
    int cfg_width  = int'(FRAME_WIDTH_RST);
    int cfg_height = int'(FRAME_HEIGHT_RST);
    int cfg_bin    = int'(BIN_THRESHOLD_RST);
    int cfg_edge   = int'(EDGE_THRESHOLD_RST);

    bit older_row [MAX_COLS];
    bit newer_row [MAX_COLS];
    int col_cnt   = 0;
    int row_cnt   = 0;
    int drain_col = 0;
    bit draining  = 1'b0;
    bit left_bit  = 1'b0;

    bit pix_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit no_idle   = 1'b0;
    int pix_gap   = 0;
    int res_stall = 0;

    int cycle_count  = 0;
    int mismatches   = 0;
    int n_pixels     = 0;
    int n_drains     = 0;
    int n_results    = 0;
    int n_frame_ends = 0;
    int n_reg_writes = 0;

    function automatic int span(input int v, input int top);
        return (v < 2) ? 2 : ((v > top) ? top : v);
    endfunction

    function automatic int level(input bit b);
        return b ? 255 : 0;
    endfunction

    function automatic int row_gradient(input int x, input int w, input bit left,
                                        input bit mid);
        if (x == 0)
            return level(newer_row[1]) - level(mid);
        if (x + 1 >= w)
            return level(mid) - level(left);
        return (level(newer_row[x + 1]) - level(left)) / 2;
    endfunction

    function automatic logic [7:0] edge_decision(input int gx, input int gy);
        int lim;
        lim = cfg_edge + 1;
        return (gx * gx + gy * gy >= lim * lim) ? EDGE_ON : EDGE_OFF;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_COLOR_MODE: begin
                cfg_color = value[0];
            end
            CFG_FRAME_WIDTH: begin
                cfg_width = int'(value[11:0]);
            end
            CFG_FRAME_HEIGHT: begin
                cfg_height = int'(value[12:0]);
            end
            CFG_BIN_THRESHOLD: begin
                cfg_bin = int'(value[7:0]);
            end
            CFG_EDGE_THRESHOLD: begin
                cfg_edge = int'(value[8:0]);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void detect_edge(input t_pixel_req req);
        int w, h, x, y, luma, gx, gy;
        bit cur, mid, old;
        t_result due;
        w = span(cfg_width, MAX_COLS);
        h = span(cfg_height, MAX_ROWS);
        if (req.kind == REQ_DRAIN) begin
            if (!draining)
                return;
            x = (drain_col >= w) ? w - 1 : drain_col;
            gx = row_gradient(x, w, (x > 0) ? newer_row[x - 1] : 1'b0, newer_row[x]);
            gy = level(newer_row[x]) - level(older_row[x]);
            due.edge_value = edge_decision(gx, gy);
            if (x + 1 >= w) begin
                due.last_of_frame = 1'b1;
                draining = 1'b0;
                drain_col = 0;
            end else begin
                due.last_of_frame = 1'b0;
                drain_col = x + 1;
            end
            edge_due.push_back(due);
            return;
        end
        if (draining) begin
            draining = 1'b0;
            drain_col = 0;
            col_cnt = 0;
            row_cnt = 0;
        end
        if (cfg_color)
            luma = (int'(LUMA_WR) * int'(req.red) + int'(LUMA_WG) * int'(req.green)
                    + int'(LUMA_WB) * int'(req.blue)) >> 16;
        else
            luma = int'(req.red);
        cur = (luma > cfg_bin);
        x = (col_cnt >= w) ? w - 1 : col_cnt;
        y = (row_cnt >= h) ? h - 1 : row_cnt;
        if (x == 0)
            left_bit = 1'b0;
        mid = newer_row[x];
        old = older_row[x];
        if (y > 0) begin
            gx = row_gradient(x, w, left_bit, mid);
            if (y == 1)
                gy = level(cur) - level(mid);
            else
                gy = (level(cur) - level(old)) / 2;
            due.edge_value = edge_decision(gx, gy);
            due.last_of_frame = 1'b0;
            edge_due.push_back(due);
        end
        older_row[x] = mid;
        newer_row[x] = cur;
        left_bit = mid;
        if (x + 1 >= w) begin
            col_cnt = 0;
            if (y + 1 >= h) begin
                row_cnt = 0;
                draining = 1'b1;
                drain_col = 0;
            end else begin
                row_cnt = y + 1;
            end
        end else begin
            col_cnt = x + 1;
        end
    endfunction

    function automatic int pause_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin : driver
        t_pixel_req nxt;
        t_reg_write wr;
        if (i_rst_n) begin
            if ($urandom_range(0, 249) == 0)
                no_idle <= !no_idle;
            if (!pix_valid || pix_taken) begin
                if (pix_gap > 0) begin
                    pix_valid <= 1'b0;
                    pix_gap <= pix_gap - 1;
                end else if (pixel_requests.size() != 0) begin
                    nxt = pixel_requests.pop_front();
                    pix_item <= nxt;
                    pix_valid <= 1'b1;
                    pix_gap <= pause_len();
                end else begin
                    pix_valid <= 1'b0;
                end
            end
            if (res_stall > 0) begin
                res_ready <= 1'b0;
                res_stall <= res_stall - 1;
            end else begin
                res_ready <= 1'b1;
                res_stall <= pause_len();
            end
            if (!cfg_valid || cfg_taken) begin
                if (reg_writes.size() != 0) begin
                    wr = reg_writes.pop_front();
                    cfg_index <= wr.index;
                    cfg_data <= wr.data;
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[binary_gradient_edge_detector] ERROR");
            $finish;
        end else if (i_rst_n) begin
            pix_taken <= pix_valid && pix_bus.ready;
            cfg_taken <= cfg_valid && cfg_bus.ready;
            if (cfg_valid && cfg_bus.ready) begin
                apply_reg(cfg_index, cfg_data);
                n_reg_writes++;
            end
            if (pix_valid && pix_bus.ready) begin
                if (pix_item.kind == REQ_DRAIN)
                    n_drains++;
                else
                    n_pixels++;
                detect_edge(pix_item);
            end
            if (edge_bus.valid && res_ready) begin
                n_results++;
                if (edge_bus.last_of_frame)
                    n_frame_ends++;
                if (edge_due.size() == 0) begin
                    $error("unexpected edge result: edge_value %0d last_of_frame %0b",
                           edge_bus.edge_value, edge_bus.last_of_frame);
                    mismatches++;
                end else begin
                    want = edge_due.pop_front();
                    if (edge_bus.edge_value !== want.edge_value) begin
                        $error("edge_value: expected %0d, got %0d", want.edge_value,
                               edge_bus.edge_value);
                        mismatches++;
                    end
                    if (edge_bus.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                               edge_bus.last_of_frame);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic settle();
        do @(posedge i_clk);
        while (pixel_requests.size() != 0 || pix_valid || reg_writes.size() != 0
               || cfg_valid || edge_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        t_reg_write wr;
        wr.index = idx;
        wr.data = CFG_DATA_W'(value);
        reg_writes.push_back(wr);
        do @(posedge i_clk);
        while (reg_writes.size() != 0 || cfg_valid);
    endtask

    function automatic logic [7:0] channel(input int tone);
        if (tone == 0)
            return 8'($urandom_range(0, 40));
        if (tone == 1)
            return 8'($urandom_range(215, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_pixel(input int r, input int g, input int b);
        t_pixel_req p;
        p.kind = REQ_PIXEL;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        pixel_requests.push_back(p);
    endfunction

    function automatic void push_drains(input int n);
        t_pixel_req p;
        for (int i = 0; i < n; i++) begin
            p.kind = REQ_DRAIN;
            p.red = 8'($urandom_range(0, 255));
            p.green = 8'($urandom_range(0, 255));
            p.blue = 8'($urandom_range(0, 255));
            pixel_requests.push_back(p);
        end
    endfunction

    function automatic void push_pixels(input int n);
        int tone;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 24) == 0)
                push_drains(1);
            tone = $urandom_range(0, 2);
            queue_pixel(channel(tone), channel(tone), channel(tone));
        end
    endfunction

    // A frame ends fully drained when it closes its phase, so that the next
    // register changes happen with no frame in progress.
    task automatic run_frame(input bit closing, output int pushed);
        int w, h, n, cut, x, y, drains;
        w = span(cfg_width, MAX_COLS);
        h = span(cfg_height, MAX_ROWS);
        n = w * h;
        pushed = 0;
        if (n > 2 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, n - 1);
            push_pixels(cut);
            pushed += cut;
            settle();
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_FRAME_WIDTH, $urandom_range(0, w - 1));
            else
                write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, h - 1));
            w = span(cfg_width, MAX_COLS);
            h = span(cfg_height, MAX_ROWS);
            x = (col_cnt >= w) ? w - 1 : col_cnt;
            y = (row_cnt >= h) ? h - 1 : row_cnt;
            n = (h - 1 - y) * w + (w - x);
        end
        push_pixels(n);
        pushed += n;
        drains = (closing || $urandom_range(0, 5) != 0) ? w : $urandom_range(0, w - 1);
        push_drains(drains);
        pushed += drains;
        if (closing && $urandom_range(0, 4) == 0)
            push_drains($urandom_range(1, 2));
    endtask

    task automatic shuffle_registers();
        int r;
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_COLOR_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            write_reg(CFG_FRAME_WIDTH, (r < 10) ? $urandom_range(0, 1) :
                      (r < 85) ? $urandom_range(2, 10) : $urandom_range(11, 48));
        end
        if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            write_reg(CFG_FRAME_HEIGHT, (r < 10) ? $urandom_range(0, 1) :
                      $urandom_range(2, 6));
        end
        if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            write_reg(CFG_BIN_THRESHOLD, (r < 15) ? 0 : (r < 30) ? 255 :
                      $urandom_range(0, 255));
        end
        if ($urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 99);
            write_reg(CFG_EDGE_THRESHOLD, (r < 15) ? 0 : (r < 25) ? 511 :
                      (r < 70) ? $urandom_range(0, 180) : $urandom_range(0, 511));
        end
    endtask

    initial begin : stimulus
        int random_items, got, phase;
        random_items = 0;
        phase = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes below the minimum, zero thresholds, single-channel input.
        write_reg(CFG_COLOR_MODE, 0);
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 0);
        write_reg(CFG_BIN_THRESHOLD, 0);
        write_reg(CFG_EDGE_THRESHOLD, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 0);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 255);
        push_drains(3);
        settle();

        // Height above the maximum, then cut mid-frame in both directions so
        // that the counts land beyond the new size; a pixel then abandons
        // the drain and starts a fresh frame.
        write_reg(CFG_COLOR_MODE, 1);
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 8191);
        write_reg(CFG_BIN_THRESHOLD, 254);
        write_reg(CFG_EDGE_THRESHOLD, 511);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 254);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 0);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 3);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        settle();
        write_reg(CFG_FRAME_WIDTH, 2);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 0);
        push_pixels(5);
        push_drains(2);
        settle();

        while (random_items < RANDOM_ITEMS) begin
            if (phase == 2) begin
                // Width above the maximum for part of the first row, then a
                // small width that leaves the column count past the row end.
                write_reg(CFG_FRAME_WIDTH, 4095);
                write_reg(CFG_FRAME_HEIGHT, 2);
                push_pixels(20);
                settle();
                write_reg(CFG_FRAME_WIDTH, 5);
                push_pixels(6);
                push_drains(5);
            end else begin
                shuffle_registers();
                for (int f = $urandom_range(1, 3); f > 0; f--) begin
                    run_frame(f == 1, got);
                    random_items += got;
                end
            end
            settle();
            phase++;
        end

        $display("Run covered %0d pixels, %0d drain requests and %0d register writes",
                 n_pixels, n_drains, n_reg_writes);
        $display("over %0d random phases; %0d edge results checked, %0d frame ends.",
                 phase, n_results, n_frame_ends);
        if (mismatches == 0)
            $display("[binary_gradient_edge_detector] OK");
        else
            $display("[binary_gradient_edge_detector] ERROR");
        $finish;
    end

endmodule
